FILE: hdl/sfdc_pkg.sv
// Shared types, constants and the CRC-32 byte step of the serial frame deframer.
package sfdc_pkg;

  // Sync sequence that opens every frame.
  localparam logic [7:0] SyncA = 8'hEF;
  localparam logic [7:0] SyncB = 8'hBE;
  localparam logic [7:0] SyncC = 8'hED;

  // Header bytes after the sync sequence: slot, length, checksum, timestamp.
  localparam int unsigned HeaderBytes = 13;
  localparam logic [5:0]  SlotMask    = 6'h3F;

  // Reflected CRC-32.
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  // Reset value of the length limit register.
  localparam logic [15:0] LimitReset = 16'd1008;

  // Default depth of the queue between the parser and the result stage.
  localparam int unsigned QueueDepthDefault = 2;

  // Frame status codes.
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusMismatch = 2'd1;
  localparam logic [1:0] StatusTooLong  = 2'd2;

  // What the parser asks the result stage to do.
  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_BYTE_LAST,
    CMD_EMPTY,
    CMD_TOO_LONG
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic [5:0]  slot;
    logic [15:0] check;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } queue_wr_t;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  payload_byte;
    logic [5:0]  slot_id;
    logic        frame_last;
    logic [1:0]  frame_status;
  } result_t;

  // One byte of the reflected CRC-32, bit by bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/sfdc_front.sv
// Byte parser: sync hunt, header capture and payload counting, issuing commands.
module sfdc_front
  import sfdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  output logic        byte_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] length_limit_i,
  input  logic        queue_full_i,
  output queue_wr_t   queue_wr_o
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_GOT_A,
    PH_GOT_B,
    PH_HEADER,
    PH_PAYLOAD
  } phase_e;

  localparam logic [3:0] HdrSlot    = 4'd0;
  localparam logic [3:0] HdrLenLo   = 4'd1;
  localparam logic [3:0] HdrLenHi   = 4'd2;
  localparam logic [3:0] HdrCheckLo = 4'd3;
  localparam logic [3:0] HdrCheckHi = 4'd4;
  localparam logic [3:0] HdrLast    = 4'(HeaderBytes - 1);

  phase_e      phase_q, phase_d;
  logic [3:0]  count_q, count_d;
  logic [5:0]  slot_q, slot_d;
  logic [15:0] length_q, length_d;
  logic [15:0] check_q, check_d;
  logic [15:0] left_q, left_d;
  logic        accept;

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    slot_d   = slot_q;
    length_d = length_q;
    check_d  = check_q;
    left_d   = left_q;
    queue_wr_o.push       = 1'b0;
    queue_wr_o.cmd.kind   = CMD_BYTE;
    queue_wr_o.cmd.data   = 8'd0;
    queue_wr_o.cmd.slot   = slot_q;
    queue_wr_o.cmd.check  = check_q;
    if (accept) begin
      unique case (phase_q)
        PH_GOT_A: begin
          if (rx_byte_i == SyncB) begin
            phase_d = PH_GOT_B;
          end else if (rx_byte_i == SyncA) begin
            phase_d = PH_GOT_A;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_GOT_B: begin
          if (rx_byte_i == SyncC) begin
            phase_d = PH_HEADER;
            count_d = 4'd0;
          end else if (rx_byte_i == SyncA) begin
            phase_d = PH_GOT_A;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_HEADER: begin
          unique case (count_q)
            HdrSlot:    slot_d          = rx_byte_i[5:0] & SlotMask;
            HdrLenLo:   length_d[7:0]   = rx_byte_i;
            HdrLenHi:   length_d[15:8]  = rx_byte_i;
            HdrCheckLo: check_d[7:0]    = rx_byte_i;
            HdrCheckHi: check_d[15:8]   = rx_byte_i;
            default: ;
          endcase
          count_d = count_q + 4'd1;
          if (count_q == HdrLast) begin
            // Length and checksum were captured on earlier beats.
            count_d = 4'd0;
            if (length_q >= length_limit_i) begin
              phase_d             = PH_HUNT;
              queue_wr_o.push     = 1'b1;
              queue_wr_o.cmd.kind = CMD_TOO_LONG;
            end else if (length_q == 16'd0) begin
              phase_d             = PH_HUNT;
              queue_wr_o.push     = 1'b1;
              queue_wr_o.cmd.kind = CMD_EMPTY;
            end else begin
              phase_d = PH_PAYLOAD;
              left_d  = length_q;
            end
          end
        end
        PH_PAYLOAD: begin
          left_d              = left_q - 16'd1;
          queue_wr_o.push     = 1'b1;
          queue_wr_o.cmd.data = rx_byte_i;
          if (left_q == 16'd1) begin
            phase_d             = PH_HUNT;
            queue_wr_o.cmd.kind = CMD_BYTE_LAST;
          end
        end
        default: begin
          phase_d = (rx_byte_i == SyncA) ? PH_GOT_A : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      count_q  <= 4'd0;
      slot_q   <= 6'd0;
      length_q <= 16'd0;
      check_q  <= 16'd0;
      left_q   <= 16'd0;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      slot_q   <= slot_d;
      length_q <= length_d;
      check_q  <= check_d;
      left_q   <= left_d;
    end
  end

endmodule

FILE: hdl/sfdc_queue.sv
// Small first-in first-out command queue between the parser and the result stage.
module sfdc_queue
  import sfdc_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  queue_wr_t wr_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      cmd_o,
  input  logic      pop_i
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam logic [AddrW-1:0]  LastAddr  = AddrW'(Depth - 1);
  localparam logic [CountW-1:0] FullCount = CountW'(Depth);

  cmd_t              mem_q [Depth];
  logic [AddrW-1:0]  wptr_q, rptr_q;
  logic [CountW-1:0] count_q;
  logic              push;
  logic              pop;

  assign full_o  = (count_q == FullCount);
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rptr_q];
  assign push    = wr_i.push && !full_o;
  assign pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_i.cmd;
    end
  end

  // Pointers wrap at the last entry so any depth works.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == LastAddr) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == LastAddr) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/sfdc_back.sv
// Result stage: runs the payload CRC and drives the registered result beat.
module sfdc_back
  import sfdc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  logic [31:0] crc_q, crc_d, crc_next;
  logic        valid_q;
  result_t     res_q, res_d;
  logic [15:0] crc_low;

  assign cmd_pop_o   = cmd_valid_i && (!valid_q || res_ready_i);
  assign crc_next    = crc_byte(crc_q, cmd_i.data);
  assign crc_low     = ~crc_next[15:0];
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    crc_d              = crc_q;
    res_d.has_byte     = 1'b0;
    res_d.payload_byte = 8'd0;
    res_d.slot_id      = cmd_i.slot;
    res_d.frame_last   = 1'b1;
    res_d.frame_status = StatusOk;
    unique case (cmd_i.kind)
      CMD_BYTE: begin
        crc_d              = crc_next;
        res_d.has_byte     = 1'b1;
        res_d.payload_byte = cmd_i.data;
        res_d.frame_last   = 1'b0;
      end
      CMD_BYTE_LAST: begin
        crc_d              = CrcInit;
        res_d.has_byte     = 1'b1;
        res_d.payload_byte = cmd_i.data;
        res_d.frame_status = (crc_low == cmd_i.check) ? StatusOk : StatusMismatch;
      end
      CMD_EMPTY: begin
        // The CRC of no bytes is zero after the final inversion.
        crc_d              = CrcInit;
        res_d.frame_status = (cmd_i.check == 16'd0) ? StatusOk : StatusMismatch;
      end
      CMD_TOO_LONG: begin
        crc_d              = CrcInit;
        res_d.frame_status = StatusTooLong;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CrcInit;
      valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        crc_q   <= crc_d;
        valid_q <= 1'b1;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/serial_frame_deframer_crc_check.sv
// Top level of the serial frame deframer with CRC-32 payload check.
//
//   Channel     Direction  Beat content
//   s_axis      in         tdata[7:0] rx_byte
//   m_axis      out        tdata[7:0] payload_byte, tdata[13:8] slot_id,
//                          tlast frame_last, tuser[0] has_byte, tuser[2:1] frame_status
//   cfg         in         cfg_data_i length_limit
//
// One byte is taken per cycle while s_axis_tready is high. A result beat reaches
// m_axis through the command queue and the output register: the parser writes the
// queue on taking the byte; the CRC stage loads that register when it is empty or read.
// The asynchronous reset puts the parser in sync hunt, empties the queue, sets the
// CRC to all ones and the length limit to 1008.
// When m_axis stalls, the command queue fills; s_axis_tready falls only once the
// queue holds QueueDepth commands, so the input keeps going while a result waits.
module serial_frame_deframer_crc_check
  import sfdc_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input byte stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [13:8] slot_id, [15:14] zero
  output logic        m_axis_tlast,   // frame_last
  output logic [2:0]  m_axis_tuser,   // [0] has_byte, [2:1] frame_status
  // Length limit register write.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] limit_q;
  queue_wr_t   queue_wr;
  logic        queue_full;
  logic        cmd_valid;
  cmd_t        cmd;
  logic        cmd_pop;
  result_t     res;

  // The register is always writable; software is to write it only while idle, and the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  sfdc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (s_axis_tvalid),
    .byte_ready_o   (s_axis_tready),
    .rx_byte_i      (s_axis_tdata),
    .length_limit_i (limit_q),
    .queue_full_i   (queue_full),
    .queue_wr_o     (queue_wr)
  );

  sfdc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (queue_wr),
    .full_o  (queue_full),
    .valid_o (cmd_valid),
    .cmd_o   (cmd),
    .pop_i   (cmd_pop)
  );

  sfdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.slot_id, res.payload_byte};
  assign m_axis_tlast = res.frame_last;
  assign m_axis_tuser = {res.frame_status, res.has_byte};

endmodule

FILE: hdl/sfdc_checker.sv
// Port-level checks on the deframer result stream, bound to the top level.
module sfdc_checker
  import sfdc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [2:0]  m_axis_tuser
);

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // A beat without a payload byte only closes a frame and carries a zero byte.
  a_nobyte_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
    else $error("beat without payload byte is not a final zero beat");

  // A status other than ok appears only on the final beat.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:1] != StatusOk) |-> m_axis_tlast)
    else $error("error status on a beat that does not close the frame");

  // A rejected length never comes with a payload byte.
  a_toolong_nobyte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:1] == StatusTooLong) |-> !m_axis_tuser[0])
    else $error("length error beat carries a payload byte");

endmodule

bind serial_frame_deframer_crc_check sfdc_checker u_sfdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
